// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check with reset disable.
`define CHK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("check failed");
// Implication check with reset disable.
`define CHK_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("check failed");
`endif

// ===== hdl/fpsc_pkg.sv =====
// Package: widths, state enum, entry type and key compare for the collision search.
package fpsc_pkg;
    localparam int HeapDepth = 65536;
    localparam int ValueBits = 16;
    localparam int Stride = 30;
    localparam int AddrBits = $clog2(HeapDepth);
    localparam int CountBits = AddrBits + 1;
    localparam int KeyBits = 82;
    localparam int PowBits = 80;
    localparam logic [0:0] CfgClass = 1'b0;
    localparam logic [0:0] CfgBound = 1'b1;

    typedef struct packed {
        logic [15:0] elem_a;
        logic [15:0] elem_b;
    } entry_t;

    typedef struct packed {
        logic        seed_taken;
        logic        match_found;
        logic [15:0] first_small;
        logic [15:0] first_large;
        logic [15:0] second_small;
        logic [15:0] second_large;
        logic        heap_empty;
        logic        heap_overflow;
    } result_t;

    typedef struct packed {
        logic        start;
        logic [15:0] elem_a;
        logic [15:0] elem_b;
    } key_req_t;

    typedef struct packed {
        logic              done;
        logic [KeyBits-1:0] key;
    } key_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SEED, ST_POP_RD, ST_POP_WAIT, ST_POP_KEY, ST_POP_CMP,
        ST_POP_LAST_RD, ST_POP_LAST_WAIT, ST_DN_RD, ST_DN_RDL, ST_DN_RDR,
        ST_DN_KEYL, ST_DN_KEYR, ST_DN_KEYI, ST_DN_DEC,
        ST_PUSH_WR, ST_UP_RD, ST_UP_WAIT, ST_UP_KEYP, ST_UP_KEYI, ST_UP_DEC,
        ST_OUT
    } state_t;

    function automatic logic key_less(input logic [KeyBits-1:0] kx,
                                      input logic [15:0] ax,
                                      input logic [KeyBits-1:0] ky,
                                      input logic [15:0] ay);
        key_less = (kx < ky) || ((kx == ky) && (ax < ay));
    endfunction
endpackage

// ===== hdl/fpsc_if.sv =====
// Valid/ready channel interface carrying one word.
interface fpsc_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fifth_power_sum_collision_search.sv =====
// Top level: heap-ordered fifth-power sum collision search.
//  channel | dir | payload
//  in      | in  | kind, seed_small, seed_large
//  out     | out | seed_taken, match_found, first/second pairs, heap_empty, heap_overflow
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// A pair key comes from the shared key unit (four multiply passes per power).
// A seed climbs the heap level by level; a step computes the two pop keys,
// then descends level by level, and the re-push climbs level by level.
// Reset clears state, count, previous pair, re-push flag and config; heap memory needs no clearing.
// One word in flight; in.ready is low until out is taken.
module fifth_power_sum_collision_search
    import fpsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data,
    fpsc_if.sink        in,
    fpsc_if.source      out
);
    state_t st_reg, st_next;
    logic [4:0]  class_reg;
    logic [16:0] bound_reg;
    logic [CountBits-1:0] count_reg, count_next;
    entry_t prev_reg, prev_next;
    entry_t cur_reg, cur_next, lft_reg, lft_next, rgt_reg, rgt_next;
    logic [AddrBits-1:0] idx_reg, idx_next;
    logic [KeyBits-1:0] kc_reg, kc_next, kl_reg, kl_next, kr_reg, kr_next;
    logic   hasr_reg, hasr_next;
    logic   do_push_reg, do_push_next;
    result_t res_reg, res_next;
    logic   ram_we;
    logic [AddrBits-1:0] ram_addr;
    entry_t ram_wdata, ram_rdata;
    key_req_t kreq;
    key_rsp_t krsp;
    logic [CountBits-1:0] lidx;
    logic [4:0] a_in;
    logic [15:0] x_in;
    logic [16:0] xs;
    logic [16:0] sm;
    logic [5:0] r1;
    logic seed_ok;

    fpsc_ram #(.Depth(HeapDepth), .Width(32)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata));
    fpsc_key u_key (.clk(clk), .rst_n(rst_n), .req(kreq), .rsp(krsp));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= '0;
            bound_reg <= 17'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgClass: class_reg <= cfg_data[4:0];
                CfgBound: bound_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign a_in = in.data.seed_small;
    assign x_in = in.data.seed_large;
    assign xs = {1'b0, x_in} + {12'd0, a_in};
    // xs < 2^17; mod 30 via reduce by 30*2048 steps is long: use 17-bit by-constant mult
    always_comb
    begin
        sm = 17'(({23'd0, xs} * 40'd34953) >> 20);
        r1 = 6'(xs - 17'(sm * 17'd30));
        if (r1 >= 6'd30)
        begin
            r1 = r1 - 6'd30;
        end
        seed_ok = ({11'd0, a_in} <= x_in) && ({1'b0, x_in} < bound_reg)
                  && (r1 == {1'b0, class_reg});
    end

    assign lidx = {idx_reg, 1'b1};

    always_comb
    begin
        st_next = st_reg;
        count_next = count_reg;
        prev_next = prev_reg;
        cur_next = cur_reg;
        lft_next = lft_reg;
        rgt_next = rgt_reg;
        idx_next = idx_reg;
        kc_next = kc_reg;
        kl_next = kl_reg;
        kr_next = kr_reg;
        hasr_next = hasr_reg;
        do_push_next = do_push_reg;
        res_next = res_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (in.valid)
                begin
                    res_next = '0;
                    if (!in.data.kind)
                    begin
                        if (!seed_ok)
                        begin
                            st_next = ST_OUT;
                        end
                        else if (count_reg == CountBits'(HeapDepth))
                        begin
                            res_next.heap_overflow = 1'b1;
                            st_next = ST_OUT;
                        end
                        else
                        begin
                            res_next.seed_taken = 1'b1;
                            cur_next = '{elem_a: {11'd0, a_in}, elem_b: x_in};
                            st_next = ST_PUSH_WR;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.heap_empty = 1'b1;
                        st_next = ST_OUT;
                    end
                    else
                    begin
                        st_next = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD: st_next = ST_POP_WAIT;
            ST_POP_WAIT:
            begin
                res_next.first_small = ram_rdata.elem_a;
                res_next.first_large = ram_rdata.elem_b;
                res_next.second_small = prev_reg.elem_a;
                res_next.second_large = prev_reg.elem_b;
                st_next = ST_POP_KEY;
            end
            ST_POP_KEY:
            begin
                if (krsp.done)
                begin
                    kc_next = krsp.key;
                    st_next = ST_POP_CMP;
                end
            end
            ST_POP_CMP:
            begin
                if (krsp.done)
                begin
                    res_next.match_found = (krsp.key == kc_reg);
                    prev_next = '{elem_a: res_reg.first_small, elem_b: res_reg.first_large};
                    count_next = count_reg - 1'b1;
                    do_push_next = (17'(res_reg.first_small) + 17'(Stride))
                                   < {1'b0, res_reg.first_large};
                    st_next = ST_POP_LAST_RD;
                end
            end
            ST_POP_LAST_RD:
            begin
                if (count_reg == '0)
                begin
                    st_next = ST_UP_DEC;
                end
                else
                begin
                    st_next = ST_POP_LAST_WAIT;
                end
            end
            ST_POP_LAST_WAIT:
            begin
                cur_next = ram_rdata;
                idx_next = '0;
                st_next = ST_DN_RD;
            end
            ST_DN_RD:
            begin
                if (lidx >= count_reg)
                begin
                    st_next = ST_UP_DEC;
                end
                else
                begin
                    hasr_next = (lidx + 1'b1) < count_reg;
                    st_next = ST_DN_RDL;
                end
            end
            ST_DN_RDL: st_next = ST_DN_RDR;
            ST_DN_RDR:
            begin
                lft_next = ram_rdata;
                st_next = ST_DN_KEYL;
            end
            ST_DN_KEYL:
            begin
                if (krsp.done)
                begin
                    kl_next = krsp.key;
                    rgt_next = ram_rdata;
                    st_next = hasr_reg ? ST_DN_KEYR : ST_DN_KEYI;
                end
            end
            ST_DN_KEYR:
            begin
                if (krsp.done)
                begin
                    kr_next = krsp.key;
                    st_next = ST_DN_KEYI;
                end
            end
            ST_DN_KEYI:
            begin
                if (krsp.done)
                begin
                    kc_next = krsp.key;
                    st_next = ST_DN_DEC;
                end
            end
            ST_DN_DEC:
            begin
                if (hasr_reg && key_less(kr_reg, rgt_reg.elem_a, kl_reg, lft_reg.elem_a))
                begin
                    if (key_less(kr_reg, rgt_reg.elem_a, kc_reg, cur_reg.elem_a))
                    begin
                        idx_next = AddrBits'(lidx + 1'b1);
                        st_next = ST_DN_RD;
                    end
                    else
                    begin
                        st_next = ST_UP_DEC;
                    end
                end
                else if (key_less(kl_reg, lft_reg.elem_a, kc_reg, cur_reg.elem_a))
                begin
                    idx_next = AddrBits'(lidx);
                    st_next = ST_DN_RD;
                end
                else
                begin
                    st_next = ST_UP_DEC;
                end
            end
            ST_PUSH_WR:
            begin
                idx_next = AddrBits'(count_reg);
                count_next = count_reg + 1'b1;
                st_next = ST_UP_RD;
            end
            ST_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    st_next = ST_OUT;
                end
                else
                begin
                    st_next = ST_UP_WAIT;
                end
            end
            ST_UP_WAIT:
            begin
                lft_next = ram_rdata;
                st_next = ST_UP_KEYP;
            end
            ST_UP_KEYP:
            begin
                if (krsp.done)
                begin
                    kl_next = krsp.key;
                    st_next = ST_UP_KEYI;
                end
            end
            ST_UP_KEYI:
            begin
                if (krsp.done)
                begin
                    if (key_less(krsp.key, cur_reg.elem_a, kl_reg, lft_reg.elem_a))
                    begin
                        idx_next = (idx_reg - 1'b1) >> 1;
                        st_next = ST_UP_RD;
                    end
                    else
                    begin
                        st_next = ST_OUT;
                    end
                end
            end
            ST_UP_DEC:
            begin
                // end of sift-down: optional re-push of advanced pair
                if (do_push_reg)
                begin
                    do_push_next = 1'b0;
                    cur_next = '{elem_a: res_reg.first_small + 16'(Stride),
                                 elem_b: res_reg.first_large};
                    st_next = ST_PUSH_WR;
                end
                else
                begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out.ready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // memory port and key requests
    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = '0;
        ram_wdata = cur_reg;
        kreq = '0;
        case (st_reg)
            ST_POP_RD: ram_addr = '0;
            ST_POP_WAIT:
            begin
                kreq.start = 1'b1;
                kreq.elem_a = ram_rdata.elem_a;
                kreq.elem_b = ram_rdata.elem_b;
            end
            ST_POP_KEY:
            begin
                if (krsp.done)
                begin
                    kreq.start = 1'b1;
                    kreq.elem_a = prev_reg.elem_a;
                    kreq.elem_b = prev_reg.elem_b;
                end
            end
            ST_POP_LAST_RD: ram_addr = AddrBits'(count_reg);
            ST_DN_RD:
            begin
                // no children left: the moving entry settles here
                if (lidx >= count_reg)
                begin
                    ram_we = 1'b1;
                    ram_addr = idx_reg;
                end
            end
            ST_DN_RDL: ram_addr = AddrBits'(lidx);
            ST_DN_RDR:
            begin
                ram_addr = AddrBits'(lidx + 1'b1);
                kreq.start = 1'b1;
                kreq.elem_a = ram_rdata.elem_a;
                kreq.elem_b = ram_rdata.elem_b;
            end
            ST_DN_KEYL:
            begin
                ram_addr = AddrBits'(lidx + 1'b1);
                if (krsp.done)
                begin
                    kreq.start = 1'b1;
                    kreq.elem_a = hasr_reg ? ram_rdata.elem_a : cur_reg.elem_a;
                    kreq.elem_b = hasr_reg ? ram_rdata.elem_b : cur_reg.elem_b;
                end
            end
            ST_DN_KEYR:
            begin
                if (krsp.done)
                begin
                    kreq.start = 1'b1;
                    kreq.elem_a = cur_reg.elem_a;
                    kreq.elem_b = cur_reg.elem_b;
                end
            end
            ST_DN_DEC:
            begin
                ram_we = 1'b1;
                ram_addr = idx_reg;
                if (hasr_reg && key_less(kr_reg, rgt_reg.elem_a, kl_reg, lft_reg.elem_a))
                begin
                    if (key_less(kr_reg, rgt_reg.elem_a, kc_reg, cur_reg.elem_a))
                    begin
                        ram_wdata = rgt_reg;
                    end
                end
                else if (key_less(kl_reg, lft_reg.elem_a, kc_reg, cur_reg.elem_a))
                begin
                    ram_wdata = lft_reg;
                end
            end
            ST_UP_RD:
            begin
                ram_we = 1'b1;
                ram_addr = idx_reg;
                if (idx_reg != '0)
                begin
                    ram_we = 1'b0;
                    ram_addr = (idx_reg - 1'b1) >> 1;
                end
            end
            ST_UP_WAIT:
            begin
                kreq.start = 1'b1;
                kreq.elem_a = ram_rdata.elem_a;
                kreq.elem_b = ram_rdata.elem_b;
            end
            ST_UP_KEYP:
            begin
                if (krsp.done)
                begin
                    kreq.start = 1'b1;
                    kreq.elem_a = cur_reg.elem_a;
                    kreq.elem_b = cur_reg.elem_b;
                end
            end
            ST_UP_KEYI:
            begin
                ram_we = 1'b1;
                ram_addr = idx_reg;
                if (krsp.done && key_less(krsp.key, cur_reg.elem_a, kl_reg, lft_reg.elem_a))
                begin
                    ram_wdata = lft_reg;
                end
                else
                begin
                    ram_we = krsp.done;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            count_reg <= '0;
            prev_reg <= '0;
            do_push_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            count_reg <= count_next;
            prev_reg <= prev_next;
            do_push_reg <= do_push_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        lft_reg <= lft_next;
        rgt_reg <= rgt_next;
        idx_reg <= idx_next;
        kc_reg <= kc_next;
        kl_reg <= kl_next;
        kr_reg <= kr_next;
        hasr_reg <= hasr_next;
        res_reg <= res_next;
    end

    assign in.ready = (st_reg == ST_IDLE);
    assign out.valid = (st_reg == ST_OUT);
    assign out.data = res_reg;

    `include "assert_macros.svh"
    `CHK(a_count_max, count_reg <= CountBits'(HeapDepth))
    `CHK_IMP(a_out_flags, out.valid, !(res_reg.seed_taken && res_reg.heap_empty))
    `CHK_IMP(a_empty_no_pop, out.valid && res_reg.heap_empty, !res_reg.match_found)
endmodule

// ===== hdl/fpsc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module fpsc_ram #(
    parameter int Depth = 16,
    parameter int Width = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/fpsc_key.sv =====
// Multi-cycle key unit: a^5 + b^5 over 82 bits with one 32x16 multiply per cycle.
module fpsc_key
    import fpsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  key_req_t req,
    output key_rsp_t rsp
);
    logic [2:0]         pc_reg, pc_next;
    logic               busy_reg, busy_next;
    logic [15:0]        op_reg, op_next;
    logic [15:0]        other_reg, other_next;
    logic               second_reg, second_next;
    logic [PowBits-1:0] acc_reg, acc_next;
    logic [KeyBits-1:0] sum_reg, sum_next;
    logic [1:0]         chunk;
    logic [31:0]        mul_a;
    logic [47:0]        prod_reg, prod_next;
    logic               done_reg, done_next;

    // acc holds v^k; multiply by v one 32-bit chunk per cycle, chunk sums kept
    always_comb
    begin
        chunk = pc_reg[1:0];
        case (chunk)
            2'd0: mul_a = acc_reg[31:0];
            2'd1: mul_a = acc_reg[63:32];
            default: mul_a = {16'd0, acc_reg[79:64]};
        endcase
    end

    logic [PowBits-1:0] part_reg, part_next;
    logic [2:0]         pow_reg, pow_next;

    always_comb
    begin
        pc_next = pc_reg;
        busy_next = busy_reg;
        op_next = op_reg;
        other_next = other_reg;
        second_next = second_reg;
        acc_next = acc_reg;
        sum_next = sum_reg;
        prod_next = mul_a * op_reg;
        part_next = part_reg;
        pow_next = pow_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next = req.elem_a;
            other_next = req.elem_b;
            second_next = 1'b0;
            acc_next = {64'd0, req.elem_a};
            sum_next = '0;
            pc_next = 3'd0;
            pow_next = 3'd1;
            part_next = '0;
        end
        else if (busy_reg)
        begin
            // pc 0..2 issue chunks, 1..3 accumulate previous product
            if (pc_reg != 3'd0)
            begin
                case (pc_reg)
                    3'd1: part_next = {32'd0, prod_reg};
                    3'd2: part_next = part_reg + {prod_reg, 32'd0};
                    default: part_next = part_reg + {prod_reg[15:0], 64'd0};
                endcase
            end
            if (pc_reg == 3'd3)
            begin
                pc_next = 3'd0;
                if (pow_reg == 3'd4)
                begin
                    if (second_reg)
                    begin
                        sum_next = sum_reg + {2'd0, part_next};
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = {2'd0, part_next};
                        second_next = 1'b1;
                        op_next = other_reg;
                        acc_next = {64'd0, other_reg};
                        pow_next = 3'd1;
                    end
                end
                else
                begin
                    acc_next = part_next;
                    pow_next = pow_reg + 3'd1;
                end
            end
            else
            begin
                pc_next = pc_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pow_reg <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            pow_reg <= pow_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        other_reg <= other_next;
        acc_reg <= acc_next;
        sum_reg <= sum_next;
        prod_reg <= prod_next;
        part_reg <= part_next;
    end

    assign rsp.done = done_reg;
    assign rsp.key = sum_reg;

    `include "assert_macros.svh"
    `CHK_IMP(a_done_idle, rsp.done, !busy_reg)
    `CHK_IMP(a_pc_range, busy_reg, pc_reg <= 3'd3)
    `CHK_IMP(a_pow_range, busy_reg, pow_reg >= 3'd1 && pow_reg <= 3'd4)
endmodule

// ===== dv/fpsc_tb_pkg.sv =====
// Testbench types: the word offered on the input channel of the collision search.
package fpsc_tb_pkg;
    typedef enum logic {
        KIND_SEED = 1'b0,
        KIND_STEP = 1'b1
    } word_kind_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  seed_small;
        logic [15:0] seed_large;
    } seed_word_t;
endpackage

// ===== dv/fpsc_result_monitor.sv =====
// Watches both channels, keeps a heap model of the search and compares every result word.
module fpsc_result_monitor
    import fpsc_pkg::*;
    import fpsc_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  seed_word_t  in_word,
    input  logic        out_valid,
    input  logic        out_ready,
    input  result_t     out_word,
    output int          pending,
    output int          fail_count
);
    entry_t      pair_heap[$];
    result_t     expected_q[$];
    logic [15:0] last_small;
    logic [15:0] last_large;
    logic [4:0]  class_reg;
    logic [16:0] bound_reg;

    assign pending = expected_q.size();

    function automatic logic [81:0] power_sum(input logic [15:0] s, input logic [15:0] l);
        logic [81:0] ws;
        logic [81:0] wl;
        ws = {66'd0, s};
        wl = {66'd0, l};
        return ws * ws * ws * ws * ws + wl * wl * wl * wl * wl;
    endfunction

    function automatic logic pair_before(input entry_t x, input entry_t y);
        logic [81:0] kx;
        logic [81:0] ky;
        kx = power_sum(x.elem_a, x.elem_b);
        ky = power_sum(y.elem_a, y.elem_b);
        return (kx < ky) || (kx == ky && x.elem_a < y.elem_a);
    endfunction

    function automatic logic heap_insert(input logic [15:0] s, input logic [15:0] l);
        int     i;
        int     p;
        entry_t t;
        if (pair_heap.size() >= HeapDepth)
            return 1'b0;
        t.elem_a = s;
        t.elem_b = l;
        pair_heap.push_back(t);
        i = pair_heap.size() - 1;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!pair_before(pair_heap[i], pair_heap[p]))
                break;
            t = pair_heap[i];
            pair_heap[i] = pair_heap[p];
            pair_heap[p] = t;
            i = p;
        end
        return 1'b1;
    endfunction

    function automatic entry_t heap_take();
        entry_t top;
        entry_t t;
        int     i;
        int     c;
        int     n;
        top = pair_heap[0];
        t = pair_heap.pop_back();
        n = pair_heap.size();
        if (n > 0)
        begin
            pair_heap[0] = t;
            i = 0;
            while (2 * i + 1 < n)
            begin
                c = 2 * i + 1;
                if (c + 1 < n && pair_before(pair_heap[c + 1], pair_heap[c]))
                    c = c + 1;
                if (!pair_before(pair_heap[c], pair_heap[i]))
                    break;
                t = pair_heap[i];
                pair_heap[i] = pair_heap[c];
                pair_heap[c] = t;
                i = c;
            end
        end
        return top;
    endfunction

    function automatic result_t predict_result(input seed_word_t w);
        result_t r;
        entry_t  e;
        logic [16:0] x;
        r = '0;
        x = {1'b0, w.seed_large};
        if (w.kind == KIND_SEED)
        begin
            if (w.seed_small <= w.seed_large && x < bound_reg &&
                (int'(w.seed_large) + int'(w.seed_small)) % Stride == int'(class_reg))
            begin
                if (heap_insert({11'd0, w.seed_small}, w.seed_large))
                    r.seed_taken = 1'b1;
                else
                    r.heap_overflow = 1'b1;
            end
        end
        else if (pair_heap.size() == 0)
            r.heap_empty = 1'b1;
        else
        begin
            e = heap_take();
            r.match_found = power_sum(e.elem_a, e.elem_b) == power_sum(last_small, last_large);
            r.first_small = e.elem_a;
            r.first_large = e.elem_b;
            r.second_small = last_small;
            r.second_large = last_large;
            last_small = e.elem_a;
            last_large = e.elem_b;
            if (int'(e.elem_a) + Stride < int'(e.elem_b))
                if (!heap_insert(e.elem_a + 16'(Stride), e.elem_b))
                    r.heap_overflow = 1'b1;
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            pair_heap.delete();
            expected_q.delete();
            last_small = '0;
            last_large = '0;
            class_reg = '0;
            bound_reg = 17'd65536;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CfgClass)
                    class_reg = cfg_data[4:0];
                else
                    bound_reg = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report("unexpected word", 32'(out_word.first_small), 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_word.seed_taken !== want.seed_taken)
                        report("seed_taken", 32'(out_word.seed_taken), 32'(want.seed_taken));
                    if (out_word.match_found !== want.match_found)
                        report("match_found", 32'(out_word.match_found), 32'(want.match_found));
                    if (out_word.first_small !== want.first_small)
                        report("first_small", 32'(out_word.first_small), 32'(want.first_small));
                    if (out_word.first_large !== want.first_large)
                        report("first_large", 32'(out_word.first_large), 32'(want.first_large));
                    if (out_word.second_small !== want.second_small)
                        report("second_small", 32'(out_word.second_small),
                               32'(want.second_small));
                    if (out_word.second_large !== want.second_large)
                        report("second_large", 32'(out_word.second_large),
                               32'(want.second_large));
                    if (out_word.heap_empty !== want.heap_empty)
                        report("heap_empty", 32'(out_word.heap_empty), 32'(want.heap_empty));
                    if (out_word.heap_overflow !== want.heap_overflow)
                        report("heap_overflow", 32'(out_word.heap_overflow),
                               32'(want.heap_overflow));
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_result(in_word));
        end
    end
endmodule

// ===== dv/fifth_power_sum_collision_search_tb.sv =====
// Testbench top: stimulus, handshake idling, configuration phases and verdict.
module fifth_power_sum_collision_search_tb;
    import fpsc_pkg::*;
    import fpsc_tb_pkg::*;

    localparam int IdleLimit = 60000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [16:0] cfg_data;
    int          tx_idle;
    int          rx_idle;
    int          pending;
    int          fail_count;
    int          quiet_cycles;
    int          cur_class;
    int          cur_bound;

    fpsc_if #(.T(seed_word_t)) in_ch (clk);
    fpsc_if #(.T(result_t)) out_ch (clk);

    fifth_power_sum_collision_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in        (in_ch.sink),
        .out       (out_ch.source)
    );

    fpsc_result_monitor monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_word    (in_ch.data),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_word   (out_ch.data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= rx_idle);

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IdleLimit)
        begin
            $display("fifth_power_sum_collision_search_tb: FAIL");
            $finish;
        end
    end

    task automatic send_word(input seed_word_t w);
        while ($urandom_range(99) < tx_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send(input word_kind_t k, input int a, input int x);
        seed_word_t w;
        w.kind = k;
        w.seed_small = 5'(a);
        w.seed_large = 16'(x);
        send_word(w);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int value);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 17'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CfgClass)
            cur_class = value & 31;
        else
            cur_bound = value & 17'h1ffff;
    endtask

    // seed that passes the filters, or a step when none exists
    task automatic send_good_seed();
        int a;
        int r;
        int lim;
        int jmin;
        int jmax;
        a = $urandom_range(30, 1);
        lim = (cur_bound > 65536) ? 65536 : cur_bound;
        r = (cur_class - a + 60) % Stride;
        jmin = (r >= a) ? 0 : 1;
        jmax = (lim - 1 - r) / Stride;
        if (cur_class >= Stride || lim - 1 < r || jmin > jmax)
            send(KIND_STEP, 0, 0);
        else if ($urandom_range(3) == 0)
            send(KIND_SEED, a, r + Stride * $urandom_range(jmax, jmin));
        else
            send(KIND_SEED, a, r + Stride * $urandom_range(jmin + 40 > jmax ? jmax : jmin + 40,
                                                            jmin));
    endtask

    task automatic random_phase(input int n);
        int dup_a;
        int dup_x;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: send(KIND_STEP, $urandom_range(31),
                                               $urandom_range(65535));
                8, 9:
                begin
                    send(KIND_SEED, $urandom_range(31), $urandom_range(65535));
                end
                10:
                begin
                    dup_a = $urandom_range(30, 1);
                    dup_x = dup_a + ((cur_class - 2 * dup_a + 90) % Stride);
                    send(KIND_SEED, dup_a, dup_x);
                    send(KIND_SEED, dup_a, dup_x);
                end
                default: send_good_seed();
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        tx_idle = 12;
        rx_idle = 84;
        cur_class = 0;
        cur_bound = 65536;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty heap, first pop of (0,0) against the reset pair, equal pairs
        send(KIND_STEP, 0, 0);
        send(KIND_SEED, 0, 0);
        send(KIND_STEP, 0, 0);
        send(KIND_SEED, 5, 25);
        send(KIND_SEED, 5, 25);
        send(KIND_SEED, 30, 65520);
        send(KIND_SEED, 31, 65529);
        send(KIND_SEED, 30, 0);
        send(KIND_SEED, 15, 65535);
        send(KIND_SEED, 1, 59);
        send(KIND_SEED, 10, 9);
        send(KIND_STEP, 31, 65535);
        send(KIND_STEP, 0, 0);
        send(KIND_STEP, 0, 0);
        send(KIND_STEP, 0, 0);
        send(KIND_STEP, 0, 0);
        write_reg(CfgClass, 30);
        write_reg(CfgBound, 2);
        send(KIND_SEED, 0, 0);
        send(KIND_SEED, 1, 1);
        write_reg(CfgClass, 31);
        write_reg(CfgBound, 131071);
        send(KIND_SEED, 1, 30);
        write_reg(CfgClass, 2);
        write_reg(CfgBound, 2);
        send(KIND_SEED, 1, 1);
        send(KIND_SEED, 0, 2);
        write_reg(CfgBound, 0);
        send(KIND_SEED, 1, 1);
        send(KIND_STEP, 0, 0);

        write_reg(CfgClass, 7);
        write_reg(CfgBound, 2000);
        random_phase(390);
        tx_idle = 84;
        rx_idle = 12;
        write_reg(CfgClass, 29);
        write_reg(CfgBound, 65536);
        random_phase(390);
        tx_idle = 0;
        rx_idle = 0;
        write_reg(CfgClass, 0);
        write_reg(CfgBound, 900);
        random_phase(390);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("fifth_power_sum_collision_search_tb: PASS");
        else
            $display("fifth_power_sum_collision_search_tb: FAIL");
        $finish;
    end
endmodule
